// ===== design/bresenham_substep_planner_unit_macros.svh =====
// Assertion macros used by the checker file of the substep planner.
`ifndef BRESENHAM_SUBSTEP_PLANNER_UNIT_MACROS_SVH
`define BRESENHAM_SUBSTEP_PLANNER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("substep planner assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("substep planner assertion failed");

`endif

// ===== design/bsp_pkg.sv =====
`timescale 1ns / 1ps

package bsp_pkg;

   // Sub-step delay resolution: the delay scale is 2^SUBDELAY_BITS - 1.
   localparam int SUBDELAY_BITS = 8;

   localparam int DIST_W  = 17;
   localparam int ERR_W   = 18;
   localparam int MAG_W   = 18;
   localparam int DELAY_W = 8;
   localparam int SKIP_W  = 8;
   localparam int NUM_W   = MAG_W + SUBDELAY_BITS;
   localparam int CNT_W   = $clog2(NUM_W + 1);

   localparam logic [DIST_W-1:0] MAX_COUNT = DIST_W'(100000);
   localparam logic [SKIP_W-1:0] SKIP_MAX  = SKIP_W'(255);
   localparam logic [SKIP_W-1:0] SKIP_ONE  = SKIP_W'(1);

   localparam logic MODE_BEGIN = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   localparam logic [1:0] KIND_DELAY  = 2'd0;
   localparam logic [1:0] KIND_NEW    = 2'd1;
   localparam logic [1:0] KIND_EXTEND = 2'd2;
   localparam logic [1:0] KIND_BEGIN  = 2'd3;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_BEGIN_BIG = 2'd1;
   localparam logic [1:0] ERR_ZERO      = 2'd2;
   localparam logic [1:0] ERR_STEP_BIG  = 2'd3;

   localparam logic REG_X_DISTANCE = 1'b0;
   localparam logic REG_Z_DISTANCE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic mode;
      logic queue_empty;
   } req_type;

   typedef struct packed {
      logic [1:0]         entry_kind;
      logic [DELAY_W-1:0] delay_value;
      logic [SKIP_W-1:0]  skip_count;
      logic               step_x;
      logic               step_z;
      logic               last;
      logic [1:0]         error_code;
   } rsp_type;

endpackage

// ===== design/bresenham_substep_planner_unit.sv =====
`timescale 1ns / 1ps

// Two-axis line stepper that plans sub-step timing for a downstream queue.
// Software writes x_distance (index 0) and z_distance (index 1) through the
// csr_ port while the unit is idle, then sends a begin request followed by
// one step request per major-axis step. Every request gives one response.
// Begin, refused steps and skip entries answer in the cycle after acceptance.
// A delay entry runs a bit-serial restoring divider, one dividend bit per
// cycle, over the 26-bit scaled error magnitude; the response follows the
// last divide step. The divider sets the rate for delay steps; other requests
// can be taken every cycle while the response side keeps up.
// The result sits in an output register. While rsp_valid is high and
// rsp_ready is low, the response holds and req_ready is low; when the
// response is taken, a new request can be accepted in the same cycle.
// Synchronous reset clears the distances, the error term, the step count,
// the minor-axis flag and the skip run, and returns to idle so rsp_valid is low.
// A refused step (zero or too many steps left) leaves all state unchanged.
module bresenham_substep_planner_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bsp_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bsp_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [bsp_pkg::DIST_W-1:0]   csr_wdata
);

   localparam int DW = bsp_pkg::DIST_W;
   localparam int EW = bsp_pkg::ERR_W;
   localparam int NW = bsp_pkg::NUM_W;
   localparam int QW = bsp_pkg::DELAY_W;
   localparam int SW = bsp_pkg::SKIP_W;
   localparam int CW = bsp_pkg::CNT_W;

   bsp_pkg::state_type state_ff, state_in;

   logic [DW-1:0] x_dist_ff, z_dist_ff;
   logic [EW-1:0] err_ff, err_in;
   logic [DW-1:0] steps_ff, steps_in;
   logic          minor_x_ff, minor_x_in;
   logic [SW-1:0] top_skip_ff, top_skip_in;
   bsp_pkg::rsp_type rsp_ff, rsp_in;

   // Divider state.
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff, div_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic accept;
   logic go_div;
   logic div_done;

   // Step datapath.
   logic signed [EW-1:0] e_val;
   logic                 x_go, z_go;
   logic [EW-1:0]        acc;
   logic [DW-1:0]        minor_dist;
   logic                 have_delay;
   logic [EW-1:0]        mag;
   logic [NW-1:0]        product;
   logic [DW-1:0]        major;
   logic [EW-1:0]        half_up;
   logic                 step_ok;
   logic [DW:0]          trial;
   logic                 trial_ge;

   assign accept = req_valid && req_ready;

   always_comb begin
      e_val      = $signed(err_ff);
      x_go       = e_val >= -$signed({1'b0, x_dist_ff});
      z_go       = e_val <= $signed({1'b0, z_dist_ff});
      acc        = err_ff - (x_go ? {1'b0, z_dist_ff} : EW'(0))
                          + (z_go ? {1'b0, x_dist_ff} : EW'(0));
      minor_dist = minor_x_ff ? x_dist_ff : z_dist_ff;
      have_delay = (minor_x_ff ? x_go : z_go) && (minor_dist != '0);
      mag        = err_ff[EW-1] ? (EW'(0) - err_ff) : err_ff;
      // scale * |e| with scale = 2^SUBDELAY_BITS - 1
      product    = {mag, {bsp_pkg::SUBDELAY_BITS{1'b0}}} - NW'(mag);
      major      = (z_dist_ff > x_dist_ff) ? z_dist_ff : x_dist_ff;
      half_up    = ({1'b0, z_dist_ff} + EW'(1)) >> 1;
      step_ok    = (steps_ff != '0) && (steps_ff <= bsp_pkg::MAX_COUNT);
      trial      = {rem_ff, num_ff[NW-1]};
      trial_ge   = trial >= {1'b0, div_ff};
   end

   assign go_div   = accept && (req_data.mode == bsp_pkg::MODE_STEP) && step_ok
                     && have_delay;
   assign div_done = (state_ff == bsp_pkg::ST_DIVIDE) && (cnt_ff == CW'(1));

   // Control: next state and handshake outputs.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         bsp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               state_in = go_div ? bsp_pkg::ST_DIVIDE : bsp_pkg::ST_RESPOND;
            end
         end
         bsp_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = bsp_pkg::ST_RESPOND;
            end
         end
         bsp_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready) begin
               if (accept) begin
                  state_in = go_div ? bsp_pkg::ST_DIVIDE : bsp_pkg::ST_RESPOND;
               end else begin
                  state_in = bsp_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = bsp_pkg::ST_IDLE;
      endcase
   end

   // Datapath: planner state, response register and divider.
   always_comb begin
      err_in      = err_ff;
      steps_in    = steps_ff;
      minor_x_in  = minor_x_ff;
      top_skip_in = top_skip_ff;
      rsp_in      = rsp_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      quo_in      = quo_ff;
      ovf_in      = ovf_ff;
      cnt_in      = cnt_ff;

      if (accept) begin
         rsp_in             = '0;
         rsp_in.skip_count  = top_skip_ff;
         if (req_data.mode == bsp_pkg::MODE_BEGIN) begin
            steps_in   = major;
            minor_x_in = z_dist_ff > x_dist_ff;
            err_in     = (z_dist_ff > x_dist_ff) ? (EW'(0) - half_up)
                                                 : ({1'b0, x_dist_ff} >> 1);
            rsp_in.entry_kind = bsp_pkg::KIND_BEGIN;
            if (major > bsp_pkg::MAX_COUNT) begin
               rsp_in.error_code = bsp_pkg::ERR_BEGIN_BIG;
            end
         end else if (steps_ff == '0) begin
            rsp_in.error_code = bsp_pkg::ERR_ZERO;
         end else if (steps_ff > bsp_pkg::MAX_COUNT) begin
            rsp_in.error_code = bsp_pkg::ERR_STEP_BIG;
         end else begin
            err_in        = acc;
            steps_in      = steps_ff - DW'(1);
            rsp_in.step_x = x_go;
            rsp_in.step_z = z_go;
            rsp_in.last   = steps_ff == DW'(1);
            if (have_delay) begin
               // The delay value is filled in when the divider finishes.
               top_skip_in       = '0;
               rsp_in.entry_kind = bsp_pkg::KIND_DELAY;
               rsp_in.skip_count = '0;
               num_in            = product;
               rem_in            = '0;
               div_in            = minor_dist;
               quo_in            = '0;
               ovf_in            = 1'b0;
               cnt_in            = CW'(NW);
            end else if (req_data.queue_empty || (top_skip_ff == '0)
                         || (top_skip_ff >= bsp_pkg::SKIP_MAX)) begin
               top_skip_in       = bsp_pkg::SKIP_ONE;
               rsp_in.entry_kind = bsp_pkg::KIND_NEW;
               rsp_in.skip_count = bsp_pkg::SKIP_ONE;
            end else begin
               top_skip_in       = top_skip_ff + SW'(1);
               rsp_in.entry_kind = bsp_pkg::KIND_EXTEND;
               rsp_in.skip_count = top_skip_ff + SW'(1);
            end
         end
      end

      if (state_ff == bsp_pkg::ST_DIVIDE) begin
         // One restoring division step per cycle; quotient bits that leave
         // the top of the 8-bit register mark saturation.
         rem_in = trial_ge ? DW'(trial - {1'b0, div_ff}) : trial[DW-1:0];
         num_in = num_ff << 1;
         ovf_in = ovf_ff | quo_ff[QW-1];
         quo_in = {quo_ff[QW-2:0], trial_ge};
         cnt_in = cnt_ff - CW'(1);
         if (div_done) begin
            rsp_in.delay_value = ovf_in ? {QW{1'b1}} : quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bsp_pkg::ST_IDLE;
         x_dist_ff   <= '0;
         z_dist_ff   <= '0;
         err_ff      <= '0;
         steps_ff    <= '0;
         minor_x_ff  <= 1'b0;
         top_skip_ff <= '0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         err_ff      <= err_in;
         steps_ff    <= steps_in;
         minor_x_ff  <= minor_x_in;
         top_skip_ff <= top_skip_in;
         cnt_ff      <= cnt_in;
         if (csr_we) begin
            case (csr_index)
               bsp_pkg::REG_X_DISTANCE: x_dist_ff <= csr_wdata;
               bsp_pkg::REG_Z_DISTANCE: z_dist_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== design/bsp_checker.sv =====
`timescale 1ns / 1ps
`include "bresenham_substep_planner_unit_macros.svh"

module bsp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bsp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bsp_pkg::rsp_type rsp_data
);

   logic begin_accept;
   logic begin_rsp;
   logic rsp_stall;
   logic step_rsp;
   logic new_skip_rsp;
   logic skip_is_one;

   assign begin_accept = req_valid && req_ready && (req_data.mode == bsp_pkg::MODE_BEGIN);
   assign begin_rsp    = rsp_valid && (rsp_data.entry_kind == bsp_pkg::KIND_BEGIN);
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign step_rsp     = rsp_valid && (rsp_data.error_code == bsp_pkg::ERR_NONE)
                         && (rsp_data.entry_kind != bsp_pkg::KIND_BEGIN);
   assign new_skip_rsp = step_rsp && (rsp_data.entry_kind == bsp_pkg::KIND_NEW);
   assign skip_is_one  = rsp_data.skip_count == bsp_pkg::SKIP_ONE;

   // A begin request is answered in the very next cycle.
   `BSP_ASSERT_NEXT(a_begin_ack, clock, reset, begin_accept, begin_rsp)

   // A stalled response keeps the unit from taking a new request.
   `BSP_ASSERT_IMPLY(a_stall_blocks, clock, reset, rsp_stall, !req_ready)

   // A stalled response holds its value.
   `BSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // Every accepted step moves at least one axis.
   `BSP_ASSERT_IMPLY(a_step_moves, clock, reset, step_rsp, rsp_data.step_x || rsp_data.step_z)

   // A new skip entry always starts its run at one.
   `BSP_ASSERT_IMPLY(a_new_skip_one, clock, reset, new_skip_rsp, skip_is_one)

endmodule

bind bresenham_substep_planner_unit bsp_checker u_bsp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
